/* src/bsfu_pkg.sv */
`default_nettype none

package bsfu_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [2:0] OP_WRITE_USER = 3'd0;
    localparam logic [2:0] OP_WRITE_ITEM = 3'd1;
    localparam logic [2:0] OP_READ_USER  = 3'd2;
    localparam logic [2:0] OP_READ_ITEM  = 3'd3;
    localparam logic [2:0] OP_TRAIN      = 3'd4;
    localparam logic [2:0] OP_PREDICT    = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GLOBAL_MEAN    = 3'd0;
    localparam logic [2:0] CFG_MIN_PREDICTION = 3'd1;
    localparam logic [2:0] CFG_MAX_PREDICTION = 3'd2;
    localparam logic [2:0] CFG_LEARNING_RATE  = 3'd3;
    localparam logic [2:0] CFG_REGULARIZATION = 3'd4;

    // Datapath widths.
    localparam int VAL_W   = 24;  // stored values, Q8.16
    localparam int ERR_W   = 25;  // rating minus prediction
    localparam int GRAD_W  = 33;  // floor(err * x / 2^16)
    localparam int DIFF_W  = 34;  // gradient minus decay term
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WB_W    = 36;  // value plus step, before saturation
    localparam int SQ_W    = 48;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR,
        ST_RD,
        ST_RD_DATA,
        ST_DOT,
        ST_PRED,
        ST_SQ,
        ST_SQ_TAKE,
        ST_VEC_ADDR,
        ST_VEC_DATA,
        ST_ERR_MUL,
        ST_DECAY_MUL,
        ST_DIFF,
        ST_RATE_MUL,
        ST_WRITE_BACK,
        ST_DONE
    } state_t;

    // Which stored value the shared update sequence is working on.
    typedef enum logic [1:0] {
        TGT_USER_BIAS,
        TGT_ITEM_BIAS,
        TGT_ITEM_VEC,
        TGT_USER_VEC
    } target_t;

endpackage

`default_nettype wire

/* src/bias_sgd_factor_update.sv */
// One item is in work at a time: a single shared multiplier runs the dot product
// and then six products per element of a train item.
// Reset loads the configuration registers with their reset values and empties
// the output register; the stores are not cleared and must be written first.
`default_nettype none

module bias_sgd_factor_update #(
    parameter int NUM_USERS  = 1024,
    parameter int NUM_ITEMS  = 1024,
    parameter int VECTOR_LEN = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input item channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // user_index, item_index, element_index, rating, write_value, zero fill
    input  wire logic [79:0]  s_tdata,
    // op
    input  wire logic [2:0]   s_tuser,
    // Result item channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // prediction, squared_error, read_value, saturated, zero fill
    output logic      [103:0] m_tdata,
    // Configuration write port.
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_wdata
);

    import bsfu_pkg::*;

    localparam int UV_DEPTH = NUM_USERS * VECTOR_LEN;
    localparam int IV_DEPTH = NUM_ITEMS * VECTOR_LEN;
    localparam int UVAW = (UV_DEPTH > 1) ? $clog2(UV_DEPTH) : 1;
    localparam int IVAW = (IV_DEPTH > 1) ? $clog2(IV_DEPTH) : 1;
    localparam int UBAW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int IBAW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int KW = $clog2(VECTOR_LEN + 2);
    localparam int ACC_W = 2 * VAL_W + $clog2(VECTOR_LEN) + 1;
    localparam int SUM_W = ACC_W + 2;

    // Input field unpacking.
    logic        [9:0]       in_user;
    logic        [9:0]       in_item;
    logic        [4:0]       in_el;
    logic signed [VAL_W-1:0] in_rating;
    logic signed [VAL_W-1:0] in_wval;
    logic                    accept;
    logic                    in_user_ok;
    logic                    in_item_ok;
    logic                    in_el_ok;

    assign in_user   = s_tdata[9:0];
    assign in_item   = s_tdata[19:10];
    assign in_el     = s_tdata[24:20];
    assign in_rating = s_tdata[48:25];
    assign in_wval   = s_tdata[72:49];

    assign in_user_ok = 32'(in_user) < 32'(NUM_USERS);
    assign in_item_ok = 32'(in_item) < 32'(NUM_ITEMS);
    assign in_el_ok   = 32'(in_el) <= 32'(VECTOR_LEN);

    // Configuration registers.
    logic signed [VAL_W-1:0] gm_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic        [VAL_W-1:0] gamma_reg;
    logic        [VAL_W-1:0] lambda_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm_reg     <= '0;
            min_reg    <= VAL_MIN;
            max_reg    <= VAL_MAX;
            gamma_reg  <= 24'd16777;
            lambda_reg <= 24'd16777;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GLOBAL_MEAN:    gm_reg     <= cfg_wdata;
                CFG_MIN_PREDICTION: min_reg    <= cfg_wdata;
                CFG_MAX_PREDICTION: max_reg    <= cfg_wdata;
                CFG_LEARNING_RATE:  gamma_reg  <= cfg_wdata;
                CFG_REGULARIZATION: lambda_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item registers and working registers.
    state_t                   state_reg, state_next;
    target_t                  tgt_reg;
    logic        [2:0]        op_reg;
    logic        [9:0]        user_reg;
    logic        [9:0]        item_reg;
    logic        [4:0]        el_reg;
    logic signed [VAL_W-1:0]  rating_reg;
    logic signed [VAL_W-1:0]  wval_reg;
    logic        [UVAW-1:0]   u_base_reg;
    logic        [IVAW-1:0]   i_base_reg;
    logic        [KW-1:0]     k_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [VAL_W-1:0]  bu_reg;
    logic signed [VAL_W-1:0]  bi_reg;
    logic signed [VAL_W-1:0]  uk_reg;
    logic signed [VAL_W-1:0]  mk_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [GRAD_W-1:0] g_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  pred_reg;
    logic        [SQ_W-1:0]   sq_reg;
    logic signed [VAL_W-1:0]  rv_reg;
    logic                     sat_reg;
    logic                     m_tvalid_reg;
    logic        [103:0]      m_tdata_reg;

    // Store ports.
    logic                    uv_we, iv_we, ub_we, ib_we;
    logic        [UVAW-1:0]  uv_addr;
    logic        [IVAW-1:0]  iv_addr;
    logic        [UBAW-1:0]  ub_addr;
    logic        [IBAW-1:0]  ib_addr;
    logic signed [VAL_W-1:0] st_wdata;
    logic signed [VAL_W-1:0] rd_uv, rd_iv, rd_ub, rd_ib;
    logic                    el_is_bias;
    logic                    out_load;

    assign el_is_bias = 32'(el_reg) == 32'(VECTOR_LEN);
    assign uv_addr = u_base_reg + UVAW'(k_reg);
    assign iv_addr = i_base_reg + IVAW'(k_reg);
    assign ub_addr = UBAW'(user_reg);
    assign ib_addr = IBAW'(item_reg);

    bsfu_ram #(.WIDTH(VAL_W), .DEPTH(UV_DEPTH)) u_uvec_ram (
        .clk(aclk), .we(uv_we), .addr(uv_addr), .wdata(st_wdata), .rdata(rd_uv)
    );
    bsfu_ram #(.WIDTH(VAL_W), .DEPTH(IV_DEPTH)) u_ivec_ram (
        .clk(aclk), .we(iv_we), .addr(iv_addr), .wdata(st_wdata), .rdata(rd_iv)
    );
    bsfu_ram #(.WIDTH(VAL_W), .DEPTH(NUM_USERS)) u_ubias_ram (
        .clk(aclk), .we(ub_we), .addr(ub_addr), .wdata(st_wdata), .rdata(rd_ub)
    );
    bsfu_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ITEMS)) u_ibias_ram (
        .clk(aclk), .we(ib_we), .addr(ib_addr), .wdata(st_wdata), .rdata(rd_ib)
    );

    // The value being updated by the shared sequence.
    logic signed [VAL_W-1:0] w_sel;

    always_comb begin
        case (tgt_reg)
            TGT_USER_BIAS: w_sel = bu_reg;
            TGT_ITEM_BIAS: w_sel = bi_reg;
            TGT_ITEM_VEC:  w_sel = mk_reg;
            default:       w_sel = uk_reg;
        endcase
    end

    // Shared multiplier operand selection.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DOT: begin
                mul_a = MUL_A_W'(rd_uv);
                mul_b = MUL_B_W'(rd_iv);
            end
            ST_SQ: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = err_reg;
            end
            ST_ERR_MUL: begin
                mul_a = (tgt_reg == TGT_ITEM_VEC) ? MUL_A_W'(uk_reg) : MUL_A_W'(mk_reg);
                mul_b = err_reg;
            end
            ST_DECAY_MUL: begin
                mul_a = MUL_A_W'(w_sel);
                mul_b = MUL_B_W'({1'b0, lambda_reg});
            end
            ST_RATE_MUL: begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = MUL_B_W'({1'b0, gamma_reg});
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Prediction: sum of mean, biases and scaled dot product, then clamped.
    // Both limits are compared at full width so that a sum far outside the
    // value range cannot wrap before it is clamped.
    logic signed [SUM_W-1:0] pred_sum;
    logic signed [SUM_W-1:0] pred_hi;
    logic signed [VAL_W-1:0] pred_c;
    logic signed [ERR_W-1:0] err_next;

    assign pred_sum = SUM_W'(gm_reg) + SUM_W'(bu_reg) + SUM_W'(bi_reg)
                    + SUM_W'(acc_reg >>> 16);
    assign pred_hi  = (pred_sum > SUM_W'(max_reg)) ? SUM_W'(max_reg) : pred_sum;
    assign pred_c   = (pred_hi < SUM_W'(min_reg)) ? min_reg : VAL_W'(pred_hi);
    assign err_next = ERR_W'(rating_reg) - ERR_W'(pred_c);

    // Write-back value with saturation.
    logic signed [WB_W-1:0]  wb_sum;
    logic signed [VAL_W-1:0] wb_val;
    logic                    wb_sat;

    assign wb_sum = WB_W'(w_sel) + WB_W'(prod_reg >>> 24);

    always_comb begin
        wb_sat = 1'b1;
        if (wb_sum > WB_W'(VAL_MAX)) begin
            wb_val = VAL_MAX;
        end else if (wb_sum < WB_W'(VAL_MIN)) begin
            wb_val = VAL_MIN;
        end else begin
            wb_val = VAL_W'(wb_sum);
            wb_sat = 1'b0;
        end
    end

    assign st_wdata = (state_reg == ST_WR) ? wval_reg : wb_val;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state, store write enables and the output load strobe.
    always_comb begin
        state_next = state_reg;
        uv_we      = 1'b0;
        iv_we      = 1'b0;
        ub_we      = 1'b0;
        ib_we      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser) inside
                        OP_WRITE_USER:
                            state_next = (in_user_ok && in_el_ok) ? ST_WR : ST_DONE;
                        OP_WRITE_ITEM:
                            state_next = (in_item_ok && in_el_ok) ? ST_WR : ST_DONE;
                        OP_READ_USER:
                            state_next = (in_user_ok && in_el_ok) ? ST_RD : ST_DONE;
                        OP_READ_ITEM:
                            state_next = (in_item_ok && in_el_ok) ? ST_RD : ST_DONE;
                        OP_TRAIN, OP_PREDICT:
                            state_next = (in_user_ok && in_item_ok) ? ST_DOT : ST_DONE;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_WR: begin
                if (op_reg == OP_WRITE_USER) begin
                    uv_we = !el_is_bias;
                    ub_we = el_is_bias;
                end else begin
                    iv_we = !el_is_bias;
                    ib_we = el_is_bias;
                end
                state_next = ST_DONE;
            end
            ST_RD:      state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_DONE;
            ST_DOT: begin
                if (k_reg == KW'(VECTOR_LEN + 1)) begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED: state_next = ST_SQ;
            ST_SQ:   state_next = ST_SQ_TAKE;
            ST_SQ_TAKE: begin
                state_next = (op_reg == OP_TRAIN) ? ST_DECAY_MUL : ST_DONE;
            end
            ST_VEC_ADDR:  state_next = ST_VEC_DATA;
            ST_VEC_DATA:  state_next = ST_ERR_MUL;
            ST_ERR_MUL:   state_next = ST_DECAY_MUL;
            ST_DECAY_MUL: state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_RATE_MUL;
            ST_RATE_MUL:  state_next = ST_WRITE_BACK;
            ST_WRITE_BACK: begin
                case (tgt_reg)
                    TGT_USER_BIAS: begin
                        ub_we      = 1'b1;
                        state_next = ST_DECAY_MUL;
                    end
                    TGT_ITEM_BIAS: begin
                        ib_we      = 1'b1;
                        state_next = ST_VEC_ADDR;
                    end
                    TGT_ITEM_VEC: begin
                        iv_we      = 1'b1;
                        state_next = ST_ERR_MUL;
                    end
                    default: begin
                        uv_we      = 1'b1;
                        state_next = (k_reg == KW'(VECTOR_LEN - 1)) ? ST_DONE
                                                                      : ST_VEC_ADDR;
                    end
                endcase
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Datapath registers, advanced by the sequencer state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_reg     <= s_tuser;
                    user_reg   <= in_user;
                    item_reg   <= in_item;
                    el_reg     <= in_el;
                    rating_reg <= in_rating;
                    wval_reg   <= in_wval;
                    u_base_reg <= UVAW'(32'(in_user) * 32'(VECTOR_LEN));
                    i_base_reg <= IVAW'(32'(in_item) * 32'(VECTOR_LEN));
                    k_reg      <= (s_tuser == OP_TRAIN || s_tuser == OP_PREDICT)
                                  ? '0 : KW'(in_el);
                    acc_reg    <= '0;
                    pred_reg   <= '0;
                    sq_reg     <= '0;
                    rv_reg     <= '0;
                    sat_reg    <= 1'b0;
                end
            end
            ST_RD_DATA: begin
                if (op_reg == OP_READ_USER) begin
                    rv_reg <= el_is_bias ? rd_ub : rd_uv;
                end else begin
                    rv_reg <= el_is_bias ? rd_ib : rd_iv;
                end
            end
            ST_DOT: begin
                // Address k goes out, product of k-1 is formed, k-2 accumulates.
                k_reg  <= k_reg + KW'(1);
                bu_reg <= rd_ub;
                bi_reg <= rd_ib;
                if (k_reg != '0 && 32'(k_reg) <= 32'(VECTOR_LEN)) begin
                    prod_reg <= prod;
                end
                if (k_reg >= KW'(2)) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end
            ST_PRED: begin
                pred_reg <= pred_c;
                err_reg  <= err_next;
            end
            ST_SQ: prod_reg <= prod;
            ST_SQ_TAKE: begin
                sq_reg  <= prod_reg[SQ_W-1:0];
                g_reg   <= GRAD_W'(err_reg);
                tgt_reg <= TGT_USER_BIAS;
                k_reg   <= '0;
            end
            ST_VEC_DATA: begin
                uk_reg  <= rd_uv;
                mk_reg  <= rd_iv;
                tgt_reg <= TGT_ITEM_VEC;
            end
            ST_ERR_MUL: prod_reg <= prod;
            ST_DECAY_MUL: begin
                if (tgt_reg == TGT_ITEM_VEC || tgt_reg == TGT_USER_VEC) begin
                    g_reg <= GRAD_W'(prod_reg >>> 16);
                end
                prod_reg <= prod;
            end
            ST_DIFF: d_reg <= DIFF_W'(g_reg) - DIFF_W'(prod_reg >>> 24);
            ST_RATE_MUL: prod_reg <= prod;
            ST_WRITE_BACK: begin
                sat_reg <= sat_reg | wb_sat;
                case (tgt_reg)
                    TGT_USER_BIAS: begin
                        tgt_reg <= TGT_ITEM_BIAS;
                        g_reg   <= GRAD_W'(err_reg);
                    end
                    TGT_ITEM_BIAS: ;
                    TGT_ITEM_VEC: begin
                        mk_reg  <= wb_val;
                        tgt_reg <= TGT_USER_VEC;
                    end
                    default: k_reg <= k_reg + KW'(1);
                endcase
            end
            default: ;
        endcase
    end

    // Output register: a finished item waits here while the next one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'd0, sat_reg, rv_reg, sq_reg, pred_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Only a train item passes the write-back step and so may flag saturation.
    a_sat_train_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && op_reg != OP_TRAIN) |-> !sat_reg)
        else $error("saturation flagged for an item that does not train");

    // The dot product counter stops one step after the last product.
    a_dot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DOT) |-> (32'(k_reg) <= 32'(VECTOR_LEN + 1)))
        else $error("dot product counter ran past its end");

    // The update pass only addresses elements inside the row.
    a_update_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VEC_ADDR) |-> (32'(k_reg) < 32'(VECTOR_LEN)))
        else $error("update pass addressed an element outside the row");

    // Loading the output register never overwrites a result not yet taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

/* src/bsfu_ram.sv */
`default_nettype none

module bsfu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
